// ===== hw/rtl/mtp_pkg.sv =====
// Package: shared types, constants and functions of the telegram parser.
package mtp_pkg;
  localparam int DEF_MAX_TEXT_CHARS = 39;
  localparam int DEF_MAX_STAMP_CHARS = 15;
  localparam int DEF_MAX_NUMBER_CHARS = 10;
  localparam int NUM_CODES = 13;
  localparam int GAS_PAREN_BIT = 13;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_NOCRC = 2'd2;

  localparam logic [3:0] F_VERSION = 4'd0;
  localparam logic [3:0] F_STAMP = 4'd1;
  localparam logic [3:0] F_SERIAL = 4'd2;
  localparam logic [3:0] F_TARIFF = 4'd7;
  localparam logic [3:0] F_GAS_SERIAL = 4'd10;
  localparam logic [3:0] F_GAS_STAMP = 4'd11;
  localparam logic [3:0] F_GAS = 4'd12;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [3:0] field_id;
    logic [7:0] char_value;
    logic [1:0] telegram_status;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] code_char(input int k, input logic [3:0] p);
    logic [95:0] s;
    case (k)
      0: s = {"1-3:0.2.8(", 16'h0};
      1: s = {"0-0:1.0.0(", 16'h0};
      2: s = {"0-0:96.1.1(", 8'h0};
      3: s = {"1-0:1.8.1(", 16'h0};
      4: s = {"1-0:1.8.2(", 16'h0};
      5: s = {"1-0:2.8.1(", 16'h0};
      6: s = {"1-0:2.8.2(", 16'h0};
      7: s = "0-0:96.14.0(";
      8: s = {"1-0:1.7.0(", 16'h0};
      9: s = {"1-0:2.7.0(", 16'h0};
      10: s = {"0-1:96.1.0(", 8'h0};
      11: s = {"0-1:24.2.1(", 8'h0};
      default: s = {"0-1:24.3.0(", 8'h0};
    endcase
    if (p > 4'd11) return 8'h00;
    return s[95 - 8 * p -: 8];
  endfunction

  function automatic logic [3:0] code_len(input int k);
    case (k) inside
      2, 10, 11, 12: return 4'd11;
      7: return 4'd12;
      default: return 4'd10;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
endpackage

// ===== hw/rtl/mtp_stream_if.sv =====
// Interface: valid/ready channel carrying one payload.
interface mtp_stream_if #(parameter int W = 8) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtp_front.sv =====
// Front end: CRC, prefix matching and value filtering; one result per byte at most.
module mtp_front import mtp_pkg::*; #(
  parameter int MAX_TEXT_CHARS = DEF_MAX_TEXT_CHARS,
  parameter int MAX_STAMP_CHARS = DEF_MAX_STAMP_CHARS,
  parameter int MAX_NUMBER_CHARS = DEF_MAX_NUMBER_CHARS
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic [7:0] b,
  output logic res_valid,
  output result_t res
);
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  logic [1:0] phase, phase_next;
  logic [15:0] running_check, running_check_next;
  logic [15:0] received_check, received_check_next;
  logic [2:0] hex_digit_count, hex_digit_count_next;
  logic [5:0] line_position, line_position_next;
  logic [13:0] code_match_mask, code_match_mask_next;
  logic [3:0] current_field, current_field_next;
  logic [5:0] value_char_count, value_char_count_next;
  logic [1:0] group_index, group_index_next;
  logic gas_old_pending, gas_old_pending_next;
  logic inside_value, inside_value_next;

  logic [15:0] crc_b;
  logic [5:0] limit;
  logic acc, is_hex, ended, found;
  logic [3:0] hv;
  logic [13:0] m;
  logic [2:0] hcnt;
  logic [15:0] rchk;

  assign crc_b = crc_byte(running_check, b);

  always_comb begin
    case (current_field) inside
      F_VERSION, F_TARIFF: limit = 6'(MAX_NUMBER_CHARS);
      F_STAMP, F_GAS_STAMP: limit = 6'(MAX_STAMP_CHARS);
      F_SERIAL, F_GAS_SERIAL: limit = 6'(MAX_TEXT_CHARS);
      default: limit = 6'(MAX_NUMBER_CHARS);
    endcase
    case (current_field) inside
      F_VERSION, F_TARIFF: acc = is_digit(b);
      F_STAMP, F_GAS_STAMP, F_SERIAL, F_GAS_SERIAL:
        acc = b != ")" && b != 8'h0D && b != 8'h0A;
      default: acc = is_digit(b) || b == ".";
    endcase
    is_hex = 1'b1;
    hv = 4'd0;
    if (is_digit(b)) hv = b[3:0];
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) hv = b[3:0] + 4'd9;
    else is_hex = 1'b0;
  end

  always_comb begin
    phase_next = phase;
    running_check_next = running_check;
    received_check_next = received_check;
    hex_digit_count_next = hex_digit_count;
    line_position_next = line_position;
    code_match_mask_next = code_match_mask;
    current_field_next = current_field;
    value_char_count_next = value_char_count;
    group_index_next = group_index;
    gas_old_pending_next = gas_old_pending;
    inside_value_next = inside_value;
    res_valid = 1'b0;
    res = '0;
    ended = value_char_count != 6'd0;
    found = 1'b0;
    m = code_match_mask;
    hcnt = hex_digit_count;
    rchk = received_check;
    if (phase == PH_DATA) begin
      running_check_next = crc_b;
      if (line_position == 6'd0 && b == "!") begin
        phase_next = PH_CHECK;
        received_check_next = '0;
        hex_digit_count_next = '0;
      end else if (b == 8'h0A) begin
        if (inside_value && ended) begin
          res_valid = 1'b1;
          res.out_kind = KIND_END;
          res.field_id = current_field;
        end
        line_position_next = '0;
        code_match_mask_next = '1;
        inside_value_next = 1'b0;
        group_index_next = '0;
        value_char_count_next = '0;
      end else begin
        if (inside_value) begin
          if (value_char_count < limit && acc) begin
            value_char_count_next = value_char_count + 6'd1;
            res_valid = 1'b1;
            res.out_kind = KIND_CHAR;
            res.field_id = current_field;
            res.char_value = b;
          end else begin
            inside_value_next = 1'b0;
            group_index_next = (group_index == 2'd1 && ended && b == ")") ? 2'd2 : 2'd0;
            if (ended) begin
              res_valid = 1'b1;
              res.out_kind = KIND_END;
              res.field_id = current_field;
            end
          end
        end else if (group_index == 2'd2) begin
          if (b == "(") begin
            inside_value_next = 1'b1;
            group_index_next = 2'd3;
            current_field_next = F_GAS;
            value_char_count_next = '0;
          end else begin
            group_index_next = '0;
          end
        end else if (code_match_mask != '0 && line_position < 6'd12) begin
          if (line_position == 6'd0 && b == "(" && gas_old_pending &&
              code_match_mask[GAS_PAREN_BIT]) begin
            gas_old_pending_next = 1'b0;
            current_field_next = F_GAS;
            inside_value_next = 1'b1;
            value_char_count_next = '0;
            group_index_next = '0;
            code_match_mask_next = '0;
          end else begin
            m[GAS_PAREN_BIT] = 1'b0;
            for (int k = 0; k < NUM_CODES; k++) begin
              if (!found && m[k]) begin
                if ({2'b00, code_len(k)} <= line_position ||
                    code_char(k, line_position[3:0]) != b) begin
                  m[k] = 1'b0;
                end else if (line_position + 6'd1 == {2'b00, code_len(k)}) begin
                  found = 1'b1;
                  current_field_next = (k == 12) ? F_GAS_STAMP : 4'(k);
                  inside_value_next = 1'b1;
                  value_char_count_next = '0;
                  group_index_next = (k == 11) ? 2'd1 : 2'd0;
                end
              end
            end
            if (found) code_match_mask_next = '0;
            else begin
              if (line_position == 6'd9 && m[12]) gas_old_pending_next = 1'b1;
              code_match_mask_next = m;
            end
          end
        end
        if (line_position < 6'd63) line_position_next = line_position + 6'd1;
      end
    end else if (phase == PH_CHECK) begin
      if (is_hex && hcnt < 3'd4) begin
        rchk = {received_check[11:0], hv};
        hcnt = hex_digit_count + 3'd1;
      end
      received_check_next = rchk;
      hex_digit_count_next = hcnt;
      if (!(is_hex && hex_digit_count < 3'd4 && hcnt < 3'd4)) begin
        res_valid = 1'b1;
        res.out_kind = KIND_DONE;
        res.telegram_status = (hcnt == 3'd0) ? ST_NOCRC :
                              (rchk == running_check) ? ST_VALID : ST_BAD;
        phase_next = PH_WAIT;
        code_match_mask_next = '1;
        inside_value_next = 1'b0;
        group_index_next = '0;
        value_char_count_next = '0;
        line_position_next = (!is_hex && b == 8'h0A) ? 6'd0 : 6'd1;
      end
    end else begin
      if (line_position == 6'd0 && b == "/") begin
        running_check_next = crc_byte(16'h0000, b);
        phase_next = PH_DATA;
        gas_old_pending_next = 1'b0;
        code_match_mask_next = '0;
        inside_value_next = 1'b0;
        group_index_next = '0;
        value_char_count_next = '0;
        line_position_next = 6'd1;
      end else if (b == 8'h0A) line_position_next = '0;
      else if (line_position < 6'd63) line_position_next = line_position + 6'd1;
    end
    if (!in_valid) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      running_check <= '0;
      received_check <= '0;
      hex_digit_count <= '0;
      line_position <= '0;
      code_match_mask <= '1;
      current_field <= '0;
      value_char_count <= '0;
      group_index <= '0;
      gas_old_pending <= 1'b0;
      inside_value <= 1'b0;
    end else if (in_valid) begin
      phase <= phase_next;
      running_check <= running_check_next;
      received_check <= received_check_next;
      hex_digit_count <= hex_digit_count_next;
      line_position <= line_position_next;
      code_match_mask <= code_match_mask_next;
      current_field <= current_field_next;
      value_char_count <= value_char_count_next;
      group_index <= group_index_next;
      gas_old_pending <= gas_old_pending_next;
      inside_value <= inside_value_next;
    end
  end
endmodule

// ===== hw/rtl/mtp_queue.sv =====
// Back end: result queue between the parser and the output channel.
module mtp_queue import mtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic push,
  input result_t wdata,
  output logic has_room,
  output logic out_valid,
  input logic out_ready,
  output result_t rdata
);
  localparam int AW = $clog2(DEPTH);
  result_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  logic pop;

  assign out_valid = count != '0;
  assign pop = out_valid && out_ready;
  assign has_room = count < (AW + 1)'(DEPTH) || pop;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/meter_telegram_parser.sv =====
// Top level: smart-meter telegram parser with CRC-16 check.
// Output: a result enters the queue at the accepting edge and is visible in the next cycle.
// Throughput: one byte per cycle while the queue has room; the combinational CRC and prefix match set the rate.
// Input stalls only while the four-entry result queue is full and not being popped.
// Reset: synchronous rst returns to header search and empties the queue.
module meter_telegram_parser import mtp_pkg::*; #(
  parameter int MAX_TEXT_CHARS = DEF_MAX_TEXT_CHARS,
  parameter int MAX_STAMP_CHARS = DEF_MAX_STAMP_CHARS,
  parameter int MAX_NUMBER_CHARS = DEF_MAX_NUMBER_CHARS
) (
  input logic clk,
  input logic rst,
  mtp_stream_if.sink rx,
  mtp_stream_if.source res
);
  logic fire, res_valid, has_room;
  result_t fres, qres;

  assign rx.ready = has_room;
  assign fire = rx.valid && has_room;

  mtp_front #(
    .MAX_TEXT_CHARS(MAX_TEXT_CHARS),
    .MAX_STAMP_CHARS(MAX_STAMP_CHARS),
    .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(fire), .b(rx.data),
    .res_valid(res_valid), .res(fres)
  );

  mtp_queue u_queue (
    .clk(clk), .rst(rst), .push(res_valid), .wdata(fres), .has_room(has_room),
    .out_valid(res.valid), .out_ready(res.ready), .rdata(qres)
  );

  assign res.data = qres;
endmodule

// ===== hw/rtl/mtp_checker.sv =====
// Checker: port-level assertions for the telegram parser.
module mtp_checker import mtp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rx_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [15:0] res_data
);
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data[15:14] != 2'd3) else $error("bad kind");
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data[15:14] == KIND_DONE |-> res_data[13:2] == 12'd0)
    else $error("done payload");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("stall");
  a_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready) else $error("stalled while empty");
endmodule

bind meter_telegram_parser mtp_checker u_chk (
  .clk(clk), .rst(rst), .rx_ready(rx.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
